// ----- rtl/zvt_pkg.sv -----
package zvt_pkg;

	localparam int MAX_ZONES = 8;
	localparam int VIEW_W    = 6;
	localparam int ZONE_W    = 3;
	localparam int MIN_W     = 16;
	localparam int SEC_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam logic [CFG_W-1:0] RST_PULSE_OPEN   = 16'd30;
	localparam logic [CFG_W-1:0] RST_PULSE_CLOSED = 16'd60;
	localparam logic [CFG_W-1:0] RST_START_DELAY  = 16'd5;
	localparam logic [CFG_W-1:0] RST_DEFAULT_RUN  = 16'd60;

	typedef enum logic [2:0] {
		OP_SEC_TICK  = 3'd0,
		OP_MIN_TICK  = 3'd1,
		OP_RUN       = 3'd2,
		OP_WINTERIZE = 3'd3,
		OP_ON        = 3'd4,
		OP_OFF       = 3'd5
	} op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PULSE_OPEN   = 2'd0,
		REG_PULSE_CLOSED = 2'd1,
		REG_START_DELAY  = 2'd2,
		REG_DEFAULT_RUN  = 2'd3
	} cfg_reg_e;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [ZONE_W-1:0] zone;
		logic [MIN_W-1:0]  run_minutes;
	} cmd_t;

	typedef struct packed {
		logic [VIEW_W-1:0] valves_open;
		logic [ZONE_W-1:0] zone_reported;
		logic [MIN_W-1:0]  minutes_remaining;
		logic [VIEW_W-1:0] zones_expired;
		logic              winterizing;
		logic              bad_zone;
	} rsp_t;

	typedef struct packed {
		logic             clear;
		logic             load;
		logic [MIN_W-1:0] load_val;
		logic             tick;
		logic             wopen;
		logic             wclose;
	} lane_ctl_t;

	typedef struct packed {
		logic              start;
		logic              stop;
		logic              sec_tick;
		logic [ZONE_W-1:0] zone;
	} win_ctl_t;

	typedef struct packed {
		logic              active_nxt;
		logic [ZONE_W-1:0] zone;
		logic              vopen;
		logic              vclose;
	} win_evt_t;

endpackage

// ----- rtl/zvt_if.sv -----
interface zvt_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface zvt_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [zvt_pkg::CFG_IDX_W-1:0] index;
	logic [zvt_pkg::CFG_W-1:0]     wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/zvt_zone_lane.sv -----
module zvt_zone_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  zvt_pkg::lane_ctl_t        ctl,
	output logic                      valve_nxt,
	output logic [zvt_pkg::MIN_W-1:0] minutes_nxt,
	output logic                      expired
);

	logic [zvt_pkg::MIN_W-1:0] minutes_q;
	logic                      valve_q;

	always_comb begin
		minutes_nxt = minutes_q;
		valve_nxt   = valve_q;
		expired     = 1'b0;
		if (ctl.clear) begin
			minutes_nxt = '0;
			valve_nxt   = 1'b0;
		end else if (ctl.load) begin
			minutes_nxt = ctl.load_val;
			valve_nxt   = (ctl.load_val != '0);
		end else if (ctl.tick) begin
			if (minutes_q != '0) begin
				minutes_nxt = minutes_q - 1'b1;
				if (minutes_q == zvt_pkg::MIN_W'(1)) begin
					valve_nxt = 1'b0;
					expired   = 1'b1;
				end
			end
		end else if (ctl.wopen) begin
			valve_nxt = 1'b1;
		end else if (ctl.wclose) begin
			valve_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minutes_q <= '0;
			valve_q   <= 1'b0;
		end else begin
			minutes_q <= minutes_nxt;
			valve_q   <= valve_nxt;
		end
	end

endmodule

// ----- rtl/zvt_winter_seq.sv -----
module zvt_winter_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  zvt_pkg::win_ctl_t         ctl,
	input  logic [zvt_pkg::SEC_W-1:0] pulse_open,
	input  logic [zvt_pkg::SEC_W-1:0] pulse_closed,
	input  logic [zvt_pkg::SEC_W-1:0] start_delay,
	output zvt_pkg::win_evt_t         evt
);

	typedef enum logic [1:0] {
		PH_DELAY  = 2'd0,
		PH_OPEN   = 2'd1,
		PH_CLOSED = 2'd2
	} phase_t;

	phase_t                       phase_q, phase_n;
	logic                         active_q, active_n;
	logic [zvt_pkg::ZONE_W-1:0]   zone_q, zone_n;
	logic [zvt_pkg::SEC_W-1:0]    secs_q, secs_n;
	logic [zvt_pkg::SEC_W-1:0]    secs_inc;
	logic [zvt_pkg::SEC_W-1:0]    limit;
	logic                         vopen, vclose;

	always_comb begin
		secs_inc = (secs_q == '1) ? secs_q : secs_q + 1'b1;
		unique case (phase_q)
			PH_OPEN:   limit = pulse_open;
			PH_CLOSED: limit = pulse_closed;
			default:   limit = start_delay;
		endcase
	end

	always_comb begin
		active_n = active_q;
		zone_n   = zone_q;
		phase_n  = phase_q;
		secs_n   = secs_q;
		vopen    = 1'b0;
		vclose   = 1'b0;
		if (ctl.start) begin
			active_n = 1'b1;
			zone_n   = ctl.zone;
			phase_n  = PH_DELAY;
			secs_n   = '0;
		end else if (ctl.stop) begin
			active_n = 1'b0;
			phase_n  = PH_DELAY;
			secs_n   = '0;
		end else if (ctl.sec_tick && active_q) begin
			if (secs_inc >= limit) begin
				secs_n = '0;
				if (phase_q == PH_OPEN) begin
					vclose  = 1'b1;
					phase_n = PH_CLOSED;
				end else begin
					vopen   = 1'b1;
					phase_n = PH_OPEN;
				end
			end else begin
				secs_n = secs_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			zone_q   <= '0;
			phase_q  <= PH_DELAY;
			secs_q   <= '0;
		end else begin
			active_q <= active_n;
			zone_q   <= zone_n;
			phase_q  <= phase_n;
			secs_q   <= secs_n;
		end
	end

	assign evt.active_nxt = active_n;
	assign evt.zone       = zone_q;
	assign evt.vopen      = vopen;
	assign evt.vclose     = vclose;

endmodule

// ----- rtl/zone_valve_timer_with_winterize_unit.sv -----
// channel | dir | handshake    | word
// cmd     | in  | valid/ready  | opcode, zone, run_minutes
// rsp     | out | valid/ready  | valves_open, zone_reported, minutes_remaining,
//         |     |              | zones_expired, winterizing, bad_zone
// cfg     | in  | valid/ready  | index, wdata (always ready)
//
// One word per cycle sustained while rsp is not stalled; a word passes the input
// register and then the result register before rsp goes valid (all zone counters
// and the winterize sequencer update in the cycle that loads the result register).
// No clearing pass after reset; cmd is ready on the first cycle.
// A stalled rsp holds one word in the result register and one in the
// input register before cmd ready drops.
module zone_valve_timer_with_winterize_unit #(
	parameter int ZONE_COUNT = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	zvt_stream_if.sink     cmd,
	zvt_stream_if.source   rsp,
	zvt_cfg_if.sink        cfg
);

	localparam logic [zvt_pkg::ZONE_W:0] ZONE_LIM = (zvt_pkg::ZONE_W+1)'(ZONE_COUNT);

	logic [zvt_pkg::CFG_W-1:0] pulse_open_q;
	logic [zvt_pkg::CFG_W-1:0] pulse_closed_q;
	logic [zvt_pkg::CFG_W-1:0] start_delay_q;
	logic [zvt_pkg::CFG_W-1:0] default_run_q;

	zvt_pkg::cmd_t cmd_s1;
	logic          v_s1;
	zvt_pkg::rsp_t rsp_s2;
	logic          v_s2;
	logic          advance;
	logic          fire;

	zvt_pkg::op_e              op;
	logic                      is_cmd;
	logic                      zone_ok;
	logic                      cmd_ok;
	logic                      is_load;
	logic [zvt_pkg::MIN_W-1:0] load_val;

	zvt_pkg::lane_ctl_t        lane_ctl [ZONE_COUNT];
	logic [ZONE_COUNT-1:0]     lane_valve;
	logic [ZONE_COUNT-1:0]     lane_exp;
	logic [zvt_pkg::MIN_W-1:0] lane_min [ZONE_COUNT];

	zvt_pkg::win_ctl_t         win_ctl;
	zvt_pkg::win_evt_t         win_evt;

	logic [zvt_pkg::MAX_ZONES-1:0] valve_all;
	logic [zvt_pkg::MAX_ZONES-1:0] exp_all;
	logic [zvt_pkg::MIN_W-1:0]     min_sel;
	zvt_pkg::rsp_t                 rsp_n;

	// config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_open_q   <= zvt_pkg::RST_PULSE_OPEN;
			pulse_closed_q <= zvt_pkg::RST_PULSE_CLOSED;
			start_delay_q  <= zvt_pkg::RST_START_DELAY;
			default_run_q  <= zvt_pkg::RST_DEFAULT_RUN;
		end else if (cfg.valid) begin
			unique case (zvt_pkg::cfg_reg_e'(cfg.index))
				zvt_pkg::REG_PULSE_OPEN:   pulse_open_q   <= cfg.wdata;
				zvt_pkg::REG_PULSE_CLOSED: pulse_closed_q <= cfg.wdata;
				zvt_pkg::REG_START_DELAY:  start_delay_q  <= cfg.wdata;
				zvt_pkg::REG_DEFAULT_RUN:  default_run_q  <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// pipeline control
	assign advance   = !v_s2 || rsp.ready;
	assign fire      = v_s1 && advance;
	assign cmd.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready)
				v_s1 <= 1'b1;
			else if (advance)
				v_s1 <= 1'b0;
			if (advance)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready)
			cmd_s1 <= cmd.data;
		if (fire)
			rsp_s2 <= rsp_n;
	end

	// decode
	always_comb begin
		op      = zvt_pkg::op_e'(cmd_s1.opcode);
		is_cmd  = 1'b0;
		is_load = 1'b0;
		unique case (op) inside
			zvt_pkg::OP_RUN, zvt_pkg::OP_ON, zvt_pkg::OP_OFF: begin
				is_cmd  = 1'b1;
				is_load = 1'b1;
			end
			zvt_pkg::OP_WINTERIZE: is_cmd = 1'b1;
			default: ;
		endcase
		unique case (op)
			zvt_pkg::OP_RUN: load_val = cmd_s1.run_minutes;
			zvt_pkg::OP_ON:  load_val = default_run_q;
			default:         load_val = '0;
		endcase
		zone_ok = ({1'b0, cmd_s1.zone} < ZONE_LIM);
		cmd_ok  = fire && is_cmd && zone_ok;
	end

	assign win_ctl.start    = cmd_ok && (op == zvt_pkg::OP_WINTERIZE);
	assign win_ctl.stop     = cmd_ok && (op != zvt_pkg::OP_WINTERIZE);
	assign win_ctl.sec_tick = fire && (op == zvt_pkg::OP_SEC_TICK);
	assign win_ctl.zone     = cmd_s1.zone;

	zvt_winter_seq u_winter (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (win_ctl),
		.pulse_open   (pulse_open_q),
		.pulse_closed (pulse_closed_q),
		.start_delay  (start_delay_q),
		.evt          (win_evt)
	);

	for (genvar i = 0; i < ZONE_COUNT; i++) begin : g_lane
		localparam logic [zvt_pkg::ZONE_W-1:0] ZID = zvt_pkg::ZONE_W'(i);

		assign lane_ctl[i].clear    = win_ctl.start;
		assign lane_ctl[i].load     = cmd_ok && is_load && (cmd_s1.zone == ZID);
		assign lane_ctl[i].load_val = load_val;
		assign lane_ctl[i].tick     = fire && (op == zvt_pkg::OP_MIN_TICK) &&
		                              !win_evt.active_nxt;
		assign lane_ctl[i].wopen    = win_evt.vopen && (win_evt.zone == ZID);
		assign lane_ctl[i].wclose   = win_evt.vclose && (win_evt.zone == ZID);

		zvt_zone_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (lane_ctl[i]),
			.valve_nxt   (lane_valve[i]),
			.minutes_nxt (lane_min[i]),
			.expired     (lane_exp[i])
		);
	end

	// result
	always_comb begin
		valve_all = '0;
		exp_all   = '0;
		min_sel   = '0;
		for (int i = 0; i < ZONE_COUNT; i++) begin
			valve_all[i] = lane_valve[i];
			exp_all[i]   = lane_exp[i];
			if (cmd_s1.zone == zvt_pkg::ZONE_W'(i))
				min_sel = lane_min[i];
		end
		rsp_n.valves_open       = valve_all[zvt_pkg::VIEW_W-1:0];
		rsp_n.zone_reported     = cmd_s1.zone;
		rsp_n.minutes_remaining = zone_ok ? min_sel : '0;
		rsp_n.zones_expired     = exp_all[zvt_pkg::VIEW_W-1:0];
		rsp_n.winterizing       = win_evt.active_nxt;
		rsp_n.bad_zone          = is_cmd && !zone_ok;
	end

	assign rsp.valid = v_s2;
	assign rsp.data  = rsp_s2;

endmodule

// ----- rtl/zvt_checker.sv -----
module zvt_checker #(
	parameter int ZONE_COUNT = 6
) (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input zvt_pkg::rsp_t rsp_data
);

	localparam logic [zvt_pkg::ZONE_W:0] ZONE_LIM = (zvt_pkg::ZONE_W+1)'(ZONE_COUNT);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp word dropped while stalled");

	a_bad_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.bad_zone |-> ({1'b0, rsp_data.zone_reported} >= ZONE_LIM))
		else $error("bad_zone flagged for a zone in range");

	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.bad_zone |->
			(rsp_data.minutes_remaining == '0) && (rsp_data.zones_expired == '0))
		else $error("bad zone word carries time or expiry");

	a_exp_winter: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.zones_expired != '0) |-> !rsp_data.winterizing)
		else $error("zone expired while winterizing");

	a_exp_closed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_data.zones_expired & rsp_data.valves_open) == '0))
		else $error("expired zone left open");

endmodule

bind zone_valve_timer_with_winterize_unit zvt_checker #(.ZONE_COUNT(ZONE_COUNT)) u_zvt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
